>>> rtl/lfu_cache_table_core_assert.svh
// Assertion macros used by the table top level.
`ifndef LFU_CACHE_TABLE_CORE_ASSERT_SVH
`define LFU_CACHE_TABLE_CORE_ASSERT_SVH

// Implication in the same cycle, clocked on clk, off during reset.
`define LCT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lct assertion failed");

// Implication into the next cycle.
`define LCT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lct assertion failed");

`endif

>>> rtl/lct_pkg.sv
// Types and constants of the LFU table.
package lct_pkg;

	localparam int unsigned SLOT_W  = 8;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned STAMP_W = 64;
	localparam int unsigned CAP_W   = 5;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [ADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;
	localparam logic [CAP_W-1:0]  CAPACITY_RESET    = 5'd16;
	localparam logic              ACT_GET           = 1'b0;
	localparam logic              ACT_PUT           = 1'b1;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TOUCH,
		CMD_WRITE,
		CMD_EVICT,
		CMD_INSERT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [SLOT_W-1:0]   slot;
		logic [KEY_W-1:0]    key;
		logic [VAL_W-1:0]    value;
		logic [STAMP_W-1:0]  stamp;
	} cmd_t;

	// Running search word handed from cell to cell.
	typedef struct packed {
		logic                hit;
		logic [SLOT_W-1:0]   hit_slot;
		logic [VAL_W-1:0]    hit_value;
		logic                free;
		logic [SLOT_W-1:0]   free_slot;
		logic                best;
		logic [SLOT_W-1:0]   best_slot;
		logic [COUNT_W-1:0]  best_count;
		logic [STAMP_W-1:0]  best_stamp;
	} chain_t;

endpackage

>>> rtl/lct_req_if.sv
// Request channel: one lookup or store word.
interface lct_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic signed [31:0] lookup_key;
	logic signed [31:0] store_value;

	modport source (output valid, action, lookup_key, store_value, input ready);
	modport sink (input valid, action, lookup_key, store_value, output ready);
endinterface

>>> rtl/lct_rsp_if.sv
// Response channel: hit flag and read data.
interface lct_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic signed [31:0] read_value;

	modport source (output valid, found, read_value, input ready);
	modport sink (input valid, found, read_value, output ready);
endinterface

>>> rtl/lfu_cache_table_core.sv
// LFU key/value table, top level. Each request word is accepted in IDLE; in SCAN the search
// wave runs down the row of entry cells (one cell per cycle); DECIDE judges hit, free slot
// and victim; when a full table must evict before inserting, DECIDE issues the eviction and
// INSERT the insert; DONE loads the response register, waiting while it is still held. One
// request is in flight at a time. There is no clearing pass after reset. Register 0 at byte
// address 0 holds the capacity limit.
`include "lfu_cache_table_core_assert.svh"
module lfu_cache_table_core
	import lct_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	lct_req_if.sink             req,
	lct_rsp_if.source           rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int unsigned OCC_W = ($clog2(CAPACITY + 1) > CAP_W) ?
		$clog2(CAPACITY + 1) : CAP_W;
	localparam int unsigned CNT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_INSERT,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic                act_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    scan_q;
	logic [OCC_W-1:0]    occ_q;
	logic [STAMP_W-1:0]  time_q;
	logic [SLOT_W-1:0]   ins_slot_q;
	cmd_t                cmd_q;
	logic                res_found_q;
	logic [VAL_W-1:0]    res_value_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [VAL_W-1:0]    out_value_q;
	logic [OCC_W-1:0]    cap_eff;
	logic                evict;
	logic [SLOT_W-1:0]   ins_slot;
	chain_t              chain [CAPACITY+1];
	chain_t              tail;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAPACITY_ADDR) ? DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= CAPACITY_RESET;
		else if (psel && penable && pwrite && paddr == REG_CAPACITY_ADDR)
			capacity_q <= pwdata[CAP_W-1:0];
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lct_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (key_q),
			.cmd       (cmd_q),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign tail    = chain[CAPACITY];
	assign cap_eff = (OCC_W'(capacity_q) > OCC_W'(CAPACITY)) ?
		OCC_W'(CAPACITY) : OCC_W'(capacity_q);
	assign evict   = (occ_q >= cap_eff) && tail.best;
	// after eviction the lowest free slot is the victim or an older hole below it
	assign ins_slot = (evict && !(tail.free && tail.free_slot < tail.best_slot)) ?
		tail.best_slot : tail.free_slot;

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.found      = out_found_q;
	assign rsp.read_value = out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			occ_q       <= '0;
			time_q      <= '0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
			act_q       <= 1'b0;
			key_q       <= '0;
			val_q       <= '0;
			ins_slot_q  <= '0;
			res_found_q <= 1'b0;
			res_value_q <= '0;
			out_found_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			cmd_q.kind <= CMD_NONE;
			if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						act_q   <= req.action;
						key_q   <= req.lookup_key;
						val_q   <= req.store_value;
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// hold until the wave leaves the last cell
					scan_q <= scan_q + CNT_W'(1);
					if (scan_q == CNT_W'(CAPACITY - 1))
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					res_found_q <= 1'b0;
					res_value_q <= '0;
					cmd_q.key   <= key_q;
					cmd_q.value <= val_q;
					cmd_q.stamp <= time_q;
					state_q     <= ST_DONE;
					if (act_q == ACT_GET) begin
						if (tail.hit) begin
							res_found_q <= 1'b1;
							res_value_q <= tail.hit_value;
							cmd_q.kind  <= CMD_TOUCH;
							cmd_q.slot  <= tail.hit_slot;
							time_q      <= time_q + STAMP_W'(1);
						end
					end else if (cap_eff != '0) begin
						if (tail.hit) begin
							res_found_q <= 1'b1;
							cmd_q.kind  <= CMD_WRITE;
							cmd_q.slot  <= tail.hit_slot;
							time_q      <= time_q + STAMP_W'(1);
						end else if (evict) begin
							cmd_q.kind <= CMD_EVICT;
							cmd_q.slot <= tail.best_slot;
							ins_slot_q <= ins_slot;
							state_q    <= ST_INSERT;
						end else if (tail.free) begin
							cmd_q.kind <= CMD_INSERT;
							cmd_q.slot <= ins_slot;
							time_q     <= time_q + STAMP_W'(1);
							occ_q      <= occ_q + OCC_W'(1);
						end
					end
				end
				ST_INSERT: begin
					cmd_q.kind  <= CMD_INSERT;
					cmd_q.slot  <= ins_slot_q;
					cmd_q.stamp <= time_q;
					time_q      <= time_q + STAMP_W'(1);
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_value_q <= res_value_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LCT_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(CAPACITY))
	`LCT_ASSERT_NXT(a_accept_scan, req.valid && req.ready, state_q == ST_SCAN)
	`LCT_ASSERT_NXT(a_evict_insert, cmd_q.kind == CMD_EVICT, cmd_q.kind == CMD_INSERT)
	`LCT_ASSERT_NXT(a_done_load, state_q == ST_DONE && (!rsp.valid || rsp.ready), rsp.valid)

endmodule

>>> rtl/lct_cell.sv
// One table entry with its stage of the search chain.
module lct_cell
	import lct_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [KEY_W-1:0]   key,
	input  cmd_t               cmd,
	input  chain_t             chain_in,
	output chain_t             chain_out
);

	logic                valid_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic [COUNT_W-1:0]  count_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic                sel;
	chain_t              nxt;

	assign sel = (cmd.slot == SLOT_W'(IDX));

	always_comb begin
		nxt = chain_in;
		if (valid_q && key_q == key && !chain_in.hit) begin
			nxt.hit       = 1'b1;
			nxt.hit_slot  = SLOT_W'(IDX);
			nxt.hit_value = value_q;
		end
		if (!valid_q && !chain_in.free) begin
			nxt.free      = 1'b1;
			nxt.free_slot = SLOT_W'(IDX);
		end
		// strict compare keeps the lower slot on a full tie
		if (valid_q && (!chain_in.best || count_q < chain_in.best_count ||
				(count_q == chain_in.best_count && stamp_q < chain_in.best_stamp))) begin
			nxt.best       = 1'b1;
			nxt.best_slot  = SLOT_W'(IDX);
			nxt.best_count = count_q;
			nxt.best_stamp = stamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			chain_out <= '0;
		end else begin
			chain_out <= nxt;
			if (sel && cmd.kind == CMD_EVICT)
				valid_q <= 1'b0;
			else if (sel && cmd.kind == CMD_INSERT)
				valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmd.kind)
				CMD_TOUCH, CMD_WRITE: begin
					if (count_q != COUNT_MAX)
						count_q <= count_q + COUNT_W'(1);
					stamp_q <= cmd.stamp;
					if (cmd.kind == CMD_WRITE)
						value_q <= cmd.value;
				end
				CMD_INSERT: begin
					key_q   <= cmd.key;
					value_q <= cmd.value;
					count_q <= COUNT_W'(1);
					stamp_q <= cmd.stamp;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> verif/lfu_cache_table_tb.sv
// Testbench for the LFU key/value table: directed and random lookups and stores.
`timescale 1ns / 100ps

// Mirror of the table that predicts each response word and checks the outcome.
class lfu_scoreboard;
	typedef struct {
		logic        found;
		logic [31:0] read_value;
	} rsp_word_t;

	bit          slot_valid [16];
	logic [31:0] slot_key   [16];
	logic [31:0] slot_value [16];
	logic [31:0] slot_count [16];
	logic [63:0] slot_stamp [16];
	logic [63:0] next_stamp;
	int unsigned filled;
	logic [4:0]  capacity;
	rsp_word_t   pending_rsp [$];
	int          errors;

	function new();
		foreach (slot_valid[i]) slot_valid[i] = 0;
		next_stamp = 0;
		filled     = 0;
		capacity   = lct_pkg::CAPACITY_RESET;
		errors     = 0;
	endfunction

	function void bump(int s);
		if (slot_count[s] != lct_pkg::COUNT_MAX)
			slot_count[s]++;
		slot_stamp[s] = next_stamp;
		next_stamp++;
	endfunction

	// Update the mirror for one accepted request word and queue its response.
	function void note_request(logic act, logic [31:0] key, logic [31:0] val);
		int hit;
		int victim;
		int unsigned cap;
		rsp_word_t r;
		hit = -1;
		victim = -1;
		cap = (capacity > 16) ? 16 : capacity;
		r.found = 0;
		r.read_value = 0;
		for (int i = 0; i < 16; i++)
			if (hit < 0 && slot_valid[i] && slot_key[i] == key)
				hit = i;
		if (act == lct_pkg::ACT_GET) begin
			if (hit >= 0) begin
				r.found = 1;
				r.read_value = slot_value[hit];
				bump(hit);
			end
		end else if (cap != 0) begin
			if (hit >= 0) begin
				r.found = 1;
				slot_value[hit] = val;
				bump(hit);
			end else begin
				if (filled >= cap) begin
					for (int i = 0; i < 16; i++) begin
						if (!slot_valid[i])
							continue;
						if (victim < 0 || slot_count[i] < slot_count[victim] ||
							(slot_count[i] == slot_count[victim] &&
							slot_stamp[i] < slot_stamp[victim]))
							victim = i;
					end
					if (victim >= 0) begin
						slot_valid[victim] = 0;
						filled--;
					end
				end
				for (int i = 0; i < 16; i++) begin
					if (!slot_valid[i]) begin
						slot_valid[i] = 1;
						slot_key[i]   = key;
						slot_value[i] = val;
						slot_count[i] = 1;
						slot_stamp[i] = next_stamp;
						next_stamp++;
						filled++;
						break;
					end
				end
			end
		end
		pending_rsp.push_back(r);
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task check_response(logic found, logic [31:0] read_value);
		rsp_word_t e;
		if (pending_rsp.size() == 0) begin
			report("response with none pending");
			return;
		end
		e = pending_rsp.pop_front();
		if (found !== e.found)
			report($sformatf("found %b, want %b", found, e.found));
		if (read_value !== e.read_value)
			report($sformatf("read_value %h, want %h", read_value, e.read_value));
	endtask
endclass

module tb;
	import lct_pkg::*;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	longint unsigned cycle_count;
	int unsigned sent;
	logic [31:0] key_pool [8];

	lfu_scoreboard table_mirror;

	lct_req_if req ();
	lct_rsp_if rsp ();

	lfu_cache_table_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req.sink),
		.rsp     (rsp.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		table_mirror = new();
		req.valid       = 0;
		req.action      = 0;
		req.lookup_key  = 0;
		req.store_value = 0;
		rsp.ready       = 0;
		psel    = 0;
		penable = 0;
		pwrite  = 0;
		paddr   = 0;
		pwdata  = 0;
		arst_n  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end
	initial cycle_count = 0;

	// Response side: random stall per word, check on handshake.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				rsp.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
			table_mirror.check_response(rsp.found, rsp.read_value);
		end
	end

	task automatic write_capacity(input logic [4:0] cap);
		@(posedge clk);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= REG_CAPACITY_ADDR;
		pwdata  <= DATA_W'(cap);
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		table_mirror.capacity = cap;
	endtask

	// Valid stays high into a back-to-back word; drop it only when idling.
	task automatic send_request(input logic act, input logic [31:0] key,
		input logic [31:0] val, input bit no_gap);
		int unsigned gap;
		gap = no_gap ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid       <= 1;
		req.action      <= act;
		req.lookup_key  <= key;
		req.store_value <= val;
		do @(posedge clk); while (!(req.valid && req.ready));
		table_mirror.note_request(act, key, val);
		sent++;
	endtask

	task automatic drain();
		req.valid <= 0;
		while (table_mirror.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Mostly reuse a small key set so hits, updates and evictions happen.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) < 8)
			return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 23);
		return $urandom();
	endfunction

	task automatic random_phase(input int n);
		bit burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0)
				burst = $urandom_range(0, 2) == 0;
			send_request(($urandom_range(0, 1) != 0) ? ACT_PUT : ACT_GET, pick_key(),
				$urandom(), burst);
		end
	endtask

	initial begin
		logic [4:0] caps [8];
		caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd9};
		foreach (key_pool[i]) key_pool[i] = $urandom();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFE8;
		sent = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed: extremes of key and value, hit, update, miss, eviction.
		send_request(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_request(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_request(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_request(ACT_GET, 32'h7FFF_FFFF, 0, 0);
		send_request(ACT_GET, 32'h0000_0000, 0, 0);
		send_request(ACT_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1);
		send_request(ACT_GET, 32'h8000_0000, 0, 1);
		for (int k = 0; k < 16; k++)
			send_request(ACT_PUT, 32'(k + 100), 32'(k), 1);
		send_request(ACT_GET, 32'd101, 0, 0);
		send_request(ACT_PUT, 32'hFFFF_FFFF, 32'h0, 0);
		drain();

		// Shrink below occupancy: new keys evict one victim each.
		write_capacity(5'd3);
		send_request(ACT_PUT, 32'd500, 32'd5, 0);
		send_request(ACT_GET, 32'd500, 0, 0);
		send_request(ACT_PUT, 32'd501, 32'd6, 0);
		drain();

		foreach (caps[c]) begin
			write_capacity(caps[c]);
			random_phase(200);
			// Hold off until the table has answered everything.
			drain();
		end

		wait (rsp.ready == 0 || 1);
		if (table_mirror.errors == 0 && table_mirror.pending_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> lfu_cache_table_core.f
+incdir+rtl
rtl/lct_pkg.sv
rtl/lct_req_if.sv
rtl/lct_rsp_if.sv
rtl/lct_cell.sv
rtl/lfu_cache_table_core.sv
verif/lfu_cache_table_tb.sv
